// ===== sv/gap_pkg.sv =====
// Shared constants and controller-to-datapath types for the global average pooling unit.
package gap_pkg;

  localparam int SAMPLE_WIDTH_DEF     = 16;
  localparam int MAX_SPATIAL_LOG2_DEF = 16;

  // Configuration registers are 17 bits wide; there are two of them.
  localparam int CFG_W       = 17;
  localparam int CFG_IDX_W   = 1;
  localparam int GROUP_IDX_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT  = 1'b1;

  typedef struct packed {
    logic                   sample_take;  // a sample beat is accepted this cycle
    logic                   group_close;  // that sample ends its group; launch division
    logic                   div_step;     // run one divider iteration
    logic                   out_load;     // move the quotient into the output register
    logic [GROUP_IDX_W-1:0] group_index;  // position of the closing group
    logic                   last_group;   // closing group is the tensor's final one
  } gap_cmd_t;

  typedef struct packed {
    logic div_last;  // divider is on its final iteration
  } gap_status_t;

endpackage

// ===== sv/gap_if.sv =====
// Valid/ready stream interfaces for the sample input and the average output.
interface gap_in_if #(
  parameter int SAMPLE_WIDTH = gap_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface gap_out_if #(
  parameter int SAMPLE_WIDTH = gap_pkg::SAMPLE_WIDTH_DEF
);
  logic                                    valid;
  logic                                    ready;
  logic signed [SAMPLE_WIDTH-1:0]          average;
  logic [gap_pkg::GROUP_IDX_W-1:0]         group_index;
  logic                                    last_group;

  modport source (output valid, output average, output group_index, output last_group,
                  input ready);
  modport sink   (input valid, input average, input group_index, input last_group,
                  output ready);
endinterface

// ===== sv/global_average_pool_unit.sv =====
// Top level of the global average pooling unit: controller, datapath and channel wiring.
//
//   channel  | direction | payload                              | role
//   ---------+-----------+--------------------------------------+------------------------------
//   in_ch    | sink      | sample                               | one Q8.8 tensor element a beat
//   out_ch   | source    | average, group_index, last_group     | one group mean a beat
//   cfg_*    | write     | cfg_index, cfg_data                  | spatial_size, group_count
//
// Samples are taken at one beat per cycle. When a sample closes a group, its sum goes to a
// restoring divider that produces one quotient bit per cycle, while the next group keeps
// accumulating. A group-closing sample is held off while the previous division is running or
// its quotient still waits for the output register, so short groups are paced by the divider.
// Reset is synchronous and active low; it clears the counters and sets both registers to one.
// The output register holds a finished beat while out_ch is stalled; input beats continue to
// be accepted during that stall until a group-closing sample finds the divider busy.
module global_average_pool_unit #(
  parameter int SAMPLE_WIDTH     = gap_pkg::SAMPLE_WIDTH_DEF,
  parameter int MAX_SPATIAL_LOG2 = gap_pkg::MAX_SPATIAL_LOG2_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gap_pkg::CFG_W-1:0]     cfg_data,
  gap_in_if.sink                        in_ch,
  gap_out_if.source                     out_ch
);
  import gap_pkg::*;

  // Counters and divisor span the largest allowed group size, 1 << MAX_SPATIAL_LOG2.
  localparam int NW = MAX_SPATIAL_LOG2 + 1;

  gap_cmd_t      cmd;
  gap_status_t   status;
  logic [NW-1:0] divisor;

  // The controller decides when a beat is taken, when a group closes and when the divider
  // iterates; it also owns the output valid flag.
  gap_ctrl #(
    .MAX_SPATIAL_LOG2 (MAX_SPATIAL_LOG2),
    .NW               (NW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .divisor   (divisor),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath sums the samples exactly, divides the magnitude and restores the sign, so
  // the mean is truncated toward zero.
  gap_dp #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .MAX_SPATIAL_LOG2 (MAX_SPATIAL_LOG2),
    .NW               (NW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .sample      (in_ch.sample),
    .divisor     (divisor),
    .cmd         (cmd),
    .status      (status),
    .average     (out_ch.average),
    .group_index (out_ch.group_index),
    .last_group  (out_ch.last_group)
  );

endmodule

// ===== sv/gap_ctrl.sv =====
// Controller: configuration registers, sample and group counters, divider sequencing.
module gap_ctrl #(
  parameter int MAX_SPATIAL_LOG2 = gap_pkg::MAX_SPATIAL_LOG2_DEF,
  parameter int NW               = MAX_SPATIAL_LOG2 + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gap_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [NW-1:0]                 divisor,
  output gap_pkg::gap_cmd_t             cmd,
  input  gap_pkg::gap_status_t          status
);
  import gap_pkg::*;

  localparam int EW   = (CFG_W > NW) ? CFG_W : NW;
  localparam int GX_W = (NW > GROUP_IDX_W) ? NW : GROUP_IDX_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [CFG_W-1:0] spatial_r, groups_r;
  logic [NW-1:0]    cnt_r, cnt_nxt;
  logic [NW-1:0]    grp_r, grp_nxt;
  logic [1:0]       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [EW-1:0]    cap, spatial_w, groups_w, eff_n, eff_g;
  logic [NW:0]      cnt_inc, grp_inc;
  logic             closing, last, div_free, take, close, load;
  logic [GX_W-1:0]  grp_wide;

  // A zero register acts as one; anything above the cap acts as the cap.
  always_comb begin
    cap       = EW'(1) << MAX_SPATIAL_LOG2;
    spatial_w = EW'(spatial_r);
    groups_w  = EW'(groups_r);
    if (spatial_w == '0) begin
      eff_n = EW'(1);
    end else if (spatial_w > cap) begin
      eff_n = cap;
    end else begin
      eff_n = spatial_w;
    end
    if (groups_w == '0) begin
      eff_g = EW'(1);
    end else if (groups_w > cap) begin
      eff_g = cap;
    end else begin
      eff_g = groups_w;
    end
  end

  assign cnt_inc  = {1'b0, cnt_r} + (NW+1)'(1);
  assign grp_inc  = {1'b0, grp_r} + (NW+1)'(1);
  assign closing  = cnt_inc >= (NW+1)'(eff_n);
  assign last     = grp_inc >= (NW+1)'(eff_g);

  assign load     = (state_r == ST_WAIT) && (!out_valid_r || out_ready);
  assign div_free = (state_r == ST_IDLE) || load;
  assign in_ready = !closing || div_free;
  assign take     = in_valid && in_ready;
  assign close    = take && closing;

  assign grp_wide = GX_W'(grp_r);

  always_comb begin
    cmd.sample_take = take;
    cmd.group_close = close;
    cmd.div_step    = (state_r == ST_DIV);
    cmd.out_load    = load;
    cmd.group_index = grp_wide[GROUP_IDX_W-1:0];
    cmd.last_group  = last;
  end

  assign divisor   = NW'(eff_n);
  assign out_valid = out_valid_r;

  always_comb begin
    cnt_nxt = cnt_r;
    grp_nxt = grp_r;
    if (take) begin
      cnt_nxt = closing ? '0 : cnt_inc[NW-1:0];
    end
    if (close) begin
      grp_nxt = last ? '0 : grp_inc[NW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (close) begin
      state_nxt = ST_DIV;
    end else begin
      unique case (state_r)
        ST_IDLE: state_nxt = ST_IDLE;
        ST_DIV:  state_nxt = status.div_last ? ST_WAIT : ST_DIV;
        ST_WAIT: state_nxt = load ? ST_IDLE : ST_WAIT;
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spatial_r   <= CFG_W'(1);
      groups_r    <= CFG_W'(1);
      cnt_r       <= '0;
      grp_r       <= '0;
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SPATIAL_SIZE: spatial_r <= cfg_data;
          REG_GROUP_COUNT:  groups_r  <= cfg_data;
          default:          spatial_r <= spatial_r;
        endcase
      end
      cnt_r       <= cnt_nxt;
      grp_r       <= grp_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/gap_dp.sv =====
// Datapath: running-sum accumulator, restoring divider and output payload registers.
module gap_dp #(
  parameter int SAMPLE_WIDTH     = gap_pkg::SAMPLE_WIDTH_DEF,
  parameter int MAX_SPATIAL_LOG2 = gap_pkg::MAX_SPATIAL_LOG2_DEF,
  parameter int NW               = MAX_SPATIAL_LOG2 + 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample,
  input  logic [NW-1:0]                      divisor,
  input  gap_pkg::gap_cmd_t                  cmd,
  output gap_pkg::gap_status_t               status,
  output logic signed [SAMPLE_WIDTH-1:0]     average,
  output logic [gap_pkg::GROUP_IDX_W-1:0]    group_index,
  output logic                               last_group
);
  import gap_pkg::*;

  localparam int SUM_W  = SAMPLE_WIDTH + MAX_SPATIAL_LOG2 + 1;
  localparam int STEP_W = $clog2(SUM_W);

  logic [SUM_W-1:0]       acc_r, acc_nxt;
  logic [SUM_W-1:0]       quo_r, quo_nxt;
  logic [NW-1:0]          rem_r, rem_nxt;
  logic [NW-1:0]          dvs_r;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic                   neg_r;
  logic [GROUP_IDX_W-1:0] gidx_r;
  logic                   glast_r;
  logic [SAMPLE_WIDTH-1:0] avg_r;
  logic [GROUP_IDX_W-1:0] out_gidx_r;
  logic                   out_last_r;

  logic [SUM_W-1:0] sample_ext, sum_in, mag, res;
  logic [NW:0]      trial, diff;
  logic             ge;

  assign sample_ext = {{(SUM_W-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};
  assign sum_in     = acc_r + sample_ext;
  assign mag        = sum_in[SUM_W-1] ? (~sum_in + SUM_W'(1)) : sum_in;

  // One quotient bit per cycle, most significant first.
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    acc_nxt  = acc_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    if (cmd.sample_take) begin
      acc_nxt = cmd.group_close ? '0 : sum_in;
    end
    if (cmd.group_close) begin
      quo_nxt  = mag;
      rem_nxt  = '0;
      step_nxt = STEP_W'(SUM_W - 1);
    end else if (cmd.div_step) begin
      quo_nxt  = {quo_r[SUM_W-2:0], ge};
      rem_nxt  = ge ? diff[NW-1:0] : trial[NW-1:0];
      step_nxt = step_r - STEP_W'(1);
    end
  end

  assign status.div_last = (step_r == '0);
  assign res = neg_r ? (~quo_r + SUM_W'(1)) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (cmd.group_close) begin
      neg_r   <= sum_in[SUM_W-1];
      dvs_r   <= divisor;
      gidx_r  <= cmd.group_index;
      glast_r <= cmd.last_group;
    end
    if (cmd.out_load) begin
      avg_r      <= res[SAMPLE_WIDTH-1:0];
      out_gidx_r <= gidx_r;
      out_last_r <= glast_r;
    end
  end

  assign average     = avg_r;
  assign group_index = out_gidx_r;
  assign last_group  = out_last_r;

endmodule
